### rtl/dfr_pkg.sv
// Shared types and constants of the start-code payload deframer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package dfr_pkg;

    // Result burst size: one input word causes at most this many result words.
    localparam int DFR_MAX_RES = 8;
    localparam int DFR_CNT_W   = $clog2(DFR_MAX_RES + 1);
    localparam int DFR_IDX_W   = $clog2(DFR_MAX_RES);

    // Configuration port widths.
    localparam int DFR_CFG_ADDR_W = 2;
    localparam int DFR_CFG_DATA_W = 8;

    // Stream constants.
    localparam logic [7:0] PREFIX_BYTE     = 8'h19;
    localparam logic [7:0] STRIP_FIRST     = 8'h7C;
    localparam logic [7:0] STRIP_SECOND    = 8'h01;
    localparam logic [7:0] START_CODE_TAIL = 8'h01;
    localparam logic [2:0] TID_RESET       = 3'd1;

    typedef enum logic [1:0] {
        ST_DATA       = 2'd0,
        ST_BAD_PREFIX = 2'd1,
        ST_NO_START   = 2'd2,
        ST_END        = 2'd3
    } status_t;

    typedef enum logic [DFR_CFG_ADDR_W-1:0] {
        CFG_WRAP_ENABLE = 2'd0,
        CFG_UNIT_TYPE   = 2'd1,
        CFG_TEMPORAL_ID = 2'd2
    } cfg_addr_t;

    // Position inside the current payload.
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,  // no payload byte yet
        PH_STRIP    = 2'd1,  // a 7C is held that may open a 7C 01 header
        PH_BODY     = 2'd2,  // payload body, one byte held back
        PH_STRIPPED = 2'd3   // header stripped, no byte yet
    } phase_t;

    typedef struct packed {
        logic       wrap_enable;
        logic [4:0] unit_type;
        logic [2:0] temporal_id_plus1;
    } dfr_cfg_t;

    typedef struct packed {
        logic [1:0] zero_run;
        logic [7:0] held_byte;
        phase_t     phase;
        logic       seen_start;
        logic       err;
    } dfr_state_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] out_byte;
        logic       frame_last;
    } dfr_result_t;

    typedef struct packed {
        logic [DFR_CNT_W-1:0]             cnt;
        dfr_result_t [DFR_MAX_RES-1:0]    res;
    } dfr_burst_t;

endpackage

`default_nettype wire

### rtl/dfr_ifs.sv
// Valid/ready channel interfaces of the deframer: input, result and configuration.
// Depends on dfr_pkg.
`default_nettype none

interface dfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, data_byte, is_last, input ready);
    modport sink   (input valid, data_byte, is_last, output ready);
endinterface

interface dfr_out_if;
    import dfr_pkg::*;
    logic       valid;
    logic       ready;
    status_t    status;
    logic [7:0] out_byte;
    logic       frame_last;

    modport source (output valid, status, out_byte, frame_last, input ready);
    modport sink   (input valid, status, out_byte, frame_last, output ready);
endinterface

interface dfr_cfg_if;
    import dfr_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [DFR_CFG_ADDR_W-1:0] addr;
    logic [DFR_CFG_DATA_W-1:0] wdata;

    modport source (output valid, addr, wdata, input ready);
    modport sink   (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

### rtl/dfr_cfg_regs.sv
// Configuration registers of the deframer, written through the config channel.
// Depends on dfr_pkg and dfr_ifs.
`default_nettype none

module dfr_cfg_regs (
    input  wire logic      clk,
    input  wire logic      rst_n,
    dfr_cfg_if.sink        wr,
    output dfr_pkg::dfr_cfg_t cfg_val
);
    import dfr_pkg::*;

    logic       wrap_enable_reg;
    logic [4:0] unit_type_reg;
    logic [2:0] temporal_id_reg;

    assign wr.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_enable_reg <= 1'b0;
            unit_type_reg   <= 5'd0;
            temporal_id_reg <= TID_RESET;
        end
        else if (wr.valid)
        begin
            // Writes to an unknown index are dropped.
            case (cfg_addr_t'(wr.addr))
                CFG_WRAP_ENABLE: wrap_enable_reg <= wr.wdata[0];
                CFG_UNIT_TYPE:   unit_type_reg   <= wr.wdata[4:0];
                CFG_TEMPORAL_ID: temporal_id_reg <= wr.wdata[2:0];
                default:         ;
            endcase
        end
    end

    assign cfg_val.wrap_enable       = wrap_enable_reg;
    assign cfg_val.unit_type         = unit_type_reg;
    assign cfg_val.temporal_id_plus1 = temporal_id_reg;

endmodule

`default_nettype wire

### rtl/dfr_step.sv
// Per-word deframing logic: next parser state and the burst of results for one byte.
// Depends on dfr_pkg.
`default_nettype none

module dfr_step (
    input  wire dfr_pkg::dfr_state_t state_cur,
    input  wire dfr_pkg::dfr_cfg_t   cfg_val,
    input  wire logic [7:0]          data_byte,
    input  wire logic                is_last,
    output dfr_pkg::dfr_state_t      state_next,
    output dfr_pkg::dfr_burst_t      burst
);
    import dfr_pkg::*;

    typedef struct packed {
        dfr_state_t st;
        dfr_burst_t b;
    } acc_t;

    acc_t acc;

    function automatic dfr_result_t mk_res(status_t s, logic [7:0] v, logic l);
        dfr_result_t r;
        r.status     = s;
        r.out_byte   = v;
        r.frame_last = l;
        return r;
    endfunction

    function automatic acc_t push(acc_t a, dfr_result_t r);
        acc_t o;
        o = a;
        if (a.b.cnt < DFR_CNT_W'(DFR_MAX_RES))
        begin
            o.b.res[a.b.cnt[DFR_IDX_W-1:0]] = r;
            o.b.cnt = a.b.cnt + 1'b1;
        end
        return o;
    endfunction

    function automatic acc_t fail(acc_t a);
        acc_t o;
        o = push(a, mk_res(ST_BAD_PREFIX, 8'h00, 1'b0));
        o.st.err = 1'b1;
        return o;
    endfunction

    // One byte that belongs to the current payload.
    function automatic acc_t feed(acc_t a, dfr_cfg_t c, logic [7:0] v);
        acc_t o;
        o = a;
        if (!a.st.err && a.st.seen_start)
        begin
            case (a.st.phase)
                PH_IDLE, PH_STRIPPED:
                begin
                    if (a.st.phase == PH_IDLE && v == STRIP_FIRST)
                    begin
                        o.st.held_byte = v;
                        o.st.phase     = PH_STRIP;
                    end
                    else if (v == PREFIX_BYTE)
                    begin
                        if (c.wrap_enable)
                        begin
                            o = push(o, mk_res(ST_DATA, 8'h00, 1'b0));
                            o = push(o, mk_res(ST_DATA,
                                {c.unit_type, c.temporal_id_plus1}, 1'b0));
                        end
                        o.st.held_byte = v;
                        o.st.phase     = PH_BODY;
                    end
                    else
                    begin
                        o = fail(o);
                    end
                end
                PH_STRIP:
                begin
                    if (v == STRIP_SECOND)
                    begin
                        o.st.held_byte = 8'h00;
                        o.st.phase     = PH_STRIPPED;
                    end
                    else
                    begin
                        o = fail(o);
                    end
                end
                PH_BODY:
                begin
                    o = push(o, mk_res(ST_DATA, a.st.held_byte, 1'b0));
                    o.st.held_byte = v;
                end
                default:
                begin
                    o = a;
                end
            endcase
        end
        return o;
    endfunction

    function automatic acc_t end_frame(acc_t a);
        acc_t o;
        o = a;
        if (!a.st.err && a.st.seen_start)
        begin
            if (a.st.phase == PH_STRIP)
                o = fail(o);
            else if (a.st.phase == PH_BODY)
                o = push(o, mk_res(ST_DATA, a.st.held_byte, 1'b1));
            o.st.held_byte = 8'h00;
            o.st.phase     = PH_IDLE;
        end
        return o;
    endfunction

    // Held zeros turn out to be payload: at most three of them.
    function automatic acc_t flush(acc_t a, dfr_cfg_t c);
        acc_t       o;
        logic [1:0] zr;
        o  = a;
        zr = a.st.zero_run;
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < zr && !o.st.err)
                o = feed(o, c, 8'h00);
        end
        o.st.zero_run = 2'd0;
        return o;
    endfunction

    always_comb
    begin
        acc.st = state_cur;
        acc.b  = '0;
        if (!state_cur.err)
        begin
            if (data_byte == 8'h00)
            begin
                // A fourth zero pushes the oldest held zero into the payload.
                if (acc.st.zero_run == 2'd3)
                    acc = feed(acc, cfg_val, 8'h00);
                else
                    acc.st.zero_run = acc.st.zero_run + 2'd1;
            end
            else if (data_byte == START_CODE_TAIL && acc.st.zero_run >= 2'd2)
            begin
                acc = end_frame(acc);
                acc.st.zero_run = 2'd0;
                if (!acc.st.err)
                begin
                    acc.st.seen_start = 1'b1;
                    acc.st.phase      = PH_IDLE;
                end
            end
            else
            begin
                acc = flush(acc, cfg_val);
                acc = feed(acc, cfg_val, data_byte);
            end

            if (is_last && !acc.st.err)
            begin
                acc = flush(acc, cfg_val);
                acc = end_frame(acc);
                if (!acc.st.err)
                begin
                    acc = push(acc, mk_res(status_t'(acc.st.seen_start ? ST_END : ST_NO_START),
                                           8'h00, 1'b0));
                    acc.st.zero_run   = 2'd0;
                    acc.st.held_byte  = 8'h00;
                    acc.st.phase      = PH_IDLE;
                    acc.st.seen_start = 1'b0;
                end
            end
        end
    end

    assign state_next = acc.st;
    assign burst      = acc.b;

endmodule

`default_nettype wire

### rtl/dfr_burst_queue.sv
// Two-slot queue of result bursts that hands out one result word per cycle while egress is ready.
// Depends on dfr_pkg and dfr_ifs.
`default_nettype none

module dfr_burst_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push_valid,
    input  wire dfr_pkg::dfr_burst_t push_burst,
    output logic                     has_room,
    dfr_out_if.source                egress
);
    import dfr_pkg::*;

    dfr_burst_t           slot_reg [2];
    logic [1:0]           cnt_reg;
    logic [1:0]           cnt_next;
    logic                 head_reg;
    logic                 head_next;
    logic [DFR_IDX_W-1:0] idx_reg;
    logic [DFR_IDX_W-1:0] idx_next;

    dfr_burst_t  head_burst;
    dfr_result_t cur;
    logic        tail;
    logic        pop_word;
    logic        pop_burst;

    assign head_burst = slot_reg[head_reg];
    assign cur        = head_burst.res[idx_reg];
    assign tail       = head_reg ^ cnt_reg[0];
    assign has_room   = (cnt_reg != 2'd2);

    assign egress.valid      = (cnt_reg != 2'd0);
    assign egress.status     = cur.status;
    assign egress.out_byte   = cur.out_byte;
    assign egress.frame_last = cur.frame_last;

    assign pop_word  = egress.valid && egress.ready;
    assign pop_burst = pop_word &&
                       (DFR_CNT_W'(idx_reg) + DFR_CNT_W'(1) == head_burst.cnt);

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        idx_next  = idx_reg;
        if (push_valid && !pop_burst)
            cnt_next = cnt_reg + 2'd1;
        else if (!push_valid && pop_burst)
            cnt_next = cnt_reg - 2'd1;
        if (pop_burst)
        begin
            head_next = ~head_reg;
            idx_next  = '0;
        end
        else if (pop_word)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            head_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            head_reg <= head_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
            slot_reg[tail] <= push_burst;
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> cnt_reg != 2'd2)
        else $error("burst pushed into a full queue");

    a_burst_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (push_burst.cnt != '0 &&
                        push_burst.cnt <= DFR_CNT_W'(DFR_MAX_RES)))
        else $error("pushed burst has a bad word count");

    a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        egress.valid |-> DFR_CNT_W'(idx_reg) < head_burst.cnt)
        else $error("read index beyond the head burst");

endmodule

`default_nettype wire

### rtl/start_code_payload_deframer.sv
// Top level of the start-code payload deframer: input register, parser state,
// config registers and result queue. Depends on dfr_pkg, dfr_ifs and all dfr_ modules.
//
// Usage:
//   ingress carries one stream byte per word (data_byte, is_last); is_last marks
//   the final byte of a stream. egress carries result words (status, out_byte,
//   frame_last): payload bytes with frame_last on the last byte of each frame,
//   the bad-prefix error, and the end-of-stream or no-start-code marker.
//   cfg is a write channel (addr, wdata); it is always ready and must only be
//   used while the block is idle.
//   An accepted byte is held in the input register and parsed from there; its
//   results go through the burst queue before egress can take them. One byte
//   produces up to six result words, handed out one per cycle while egress is ready.
//   Throughput is one byte per cycle as long as each byte yields at most one
//   result; that rate is set by the single-word egress port. Longer bursts
//   (wrap headers, end of stream flush) stall ingress for their extra words.
//   Results are buffered in a two-burst queue, so ingress keeps flowing while a
//   finished result waits on egress. If egress stalls, the queue fills and
//   ingress ready drops; nothing is lost.
//   Reset clears the parser and queue and loads the register defaults. After a
//   bad prefix the block swallows all input until the next reset.
`default_nettype none

module start_code_payload_deframer (
    input  wire logic clk,
    input  wire logic rst_n,
    dfr_in_if.sink    ingress,
    dfr_out_if.source egress,
    dfr_cfg_if.sink   cfg
);
    import dfr_pkg::*;

    // Input register.
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Parser state, updated when the registered byte is processed.
    dfr_state_t state_reg;
    dfr_state_t state_next;

    dfr_cfg_t   cfg_val;
    dfr_burst_t burst;
    logic       q_has_room;
    logic       advance;
    logic       push_valid;
    logic       in_take;

    dfr_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (cfg),
        .cfg_val (cfg_val)
    );

    dfr_step u_step (
        .state_cur  (state_reg),
        .cfg_val    (cfg_val),
        .data_byte  (in_byte_reg),
        .is_last    (in_last_reg),
        .state_next (state_next),
        .burst      (burst)
    );

    dfr_burst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_burst (burst),
        .has_room   (q_has_room),
        .egress     (egress)
    );

    // The registered byte moves on whenever the queue has a free slot; bytes
    // that produce no result leave nothing in the queue.
    assign advance       = in_vld_reg && q_has_room;
    assign push_valid    = advance && (burst.cnt != '0);
    assign ingress.ready = !in_vld_reg || q_has_room;
    assign in_take       = ingress.valid && ingress.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            state_reg  <= '0;
        end
        else
        begin
            if (in_take)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= ingress.data_byte;
            in_last_reg <= ingress.is_last;
        end
    end

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.err |=> state_reg.err)
        else $error("error state left without reset");

    a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && state_reg.err) |-> !push_valid)
        else $error("result produced after a bad prefix");

    a_stream_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && in_last_reg && !state_next.err) |->
            (burst.res[DFR_IDX_W'(burst.cnt - 1'b1)].status == ST_END ||
             burst.res[DFR_IDX_W'(burst.cnt - 1'b1)].status == ST_NO_START))
        else $error("stream end without an end marker");

endmodule

`default_nettype wire

### sim/tb_start_code_payload_deframer.sv
// Self-checking testbench of the start-code payload deframer: directed and random byte
// streams, a prediction scoreboard and random stalls on both channels.
// Depends on dfr_pkg, dfr_ifs and the RTL of start_code_payload_deframer.
`timescale 1ns / 1ps

module tb_start_code_payload_deframer;
    import dfr_pkg::*;

    // Settling time after the last expected word, before a register write or the verdict.
    localparam int DRAIN_CYCLES    = 16;
    // Random stimulus size, split into phases that each run with their own register setting.
    localparam int RANDOM_ITEMS    = 400;
    localparam int ITEMS_PER_PHASE = 80;
    // Hard stop for the whole run, far beyond the slowest legal run.
    localparam int TIMEOUT_NS      = 2_000_000;

    // Register index that the block does not decode; writes to it must change nothing.
    localparam logic [DFR_CFG_ADDR_W-1:0] CFG_UNUSED_ADDR = 2'd3;

    // The three ways the final stream breaks the payload prefix.
    typedef enum int {
        BAD_FIRST_BYTE,
        LONE_STRIP,
        DOUBLE_STRIP
    } prefix_fault_t;

    // Parser state as the scoreboard tracks it.
    typedef struct {
        logic [1:0] zeros;       // zeros held back
        logic [7:0] held;        // payload byte held back
        logic       held_ok;
        logic       strip_wait;  // held byte is a 7C that may open a 7C 01 header
        phase_t     phase;
        logic       started;     // a start code has been seen in this stream
        logic       stuck;       // a bad prefix was seen; everything is dropped
    } parse_state_t;

    // The scoreboard predicts the result words of every accepted byte and checks the
    // words that leave the block against them in order.
    class deframer_scoreboard;
        dfr_cfg_t     regs;
        parse_state_t ps;
        dfr_result_t  expected_words[$];
        int           words_this_byte;
        int           failures;

        function new();
            regs.wrap_enable       = 1'b0;
            regs.unit_type         = 5'd0;
            regs.temporal_id_plus1 = TID_RESET;
            ps.stuck               = 1'b0;
            clear_stream();
            failures = 0;
        endfunction

        function void clear_stream();
            ps.zeros      = 2'd0;
            ps.held       = 8'h00;
            ps.held_ok    = 1'b0;
            ps.strip_wait = 1'b0;
            ps.phase      = PH_IDLE;
            ps.started    = 1'b0;
        endfunction

        function void push_word(status_t s, logic [7:0] b, logic fl);
            dfr_result_t w;
            if (words_this_byte >= DFR_MAX_RES)
                return;
            w.status     = s;
            w.out_byte   = b;
            w.frame_last = fl;
            expected_words.push_back(w);
            words_this_byte++;
        endfunction

        function void bad_prefix();
            push_word(ST_BAD_PREFIX, 8'h00, 1'b0);
            ps.stuck = 1'b1;
        endfunction

        // One byte that is known to belong to the current payload.
        function void take_payload(logic [7:0] b);
            if (ps.stuck || !ps.started)
                return;
            case (ps.phase)
                PH_IDLE, PH_STRIPPED:
                begin
                    if (ps.phase == PH_IDLE && b == STRIP_FIRST)
                    begin
                        ps.held       = b;
                        ps.held_ok    = 1'b1;
                        ps.strip_wait = 1'b1;
                        ps.phase      = PH_STRIP;
                    end
                    else if (b == PREFIX_BYTE)
                    begin
                        if (regs.wrap_enable)
                        begin
                            push_word(ST_DATA, 8'h00, 1'b0);
                            push_word(ST_DATA, {regs.unit_type, regs.temporal_id_plus1},
                                      1'b0);
                        end
                        ps.held    = b;
                        ps.held_ok = 1'b1;
                        ps.phase   = PH_BODY;
                    end
                    else
                        bad_prefix();
                end
                PH_STRIP:
                begin
                    if (b == STRIP_SECOND)
                    begin
                        ps.held_ok    = 1'b0;
                        ps.held       = 8'h00;
                        ps.strip_wait = 1'b0;
                        ps.phase      = PH_STRIPPED;
                    end
                    else
                        bad_prefix();
                end
                default:
                begin
                    push_word(ST_DATA, ps.held, 1'b0);
                    ps.held = b;
                end
            endcase
        endfunction

        function void close_frame();
            if (ps.stuck || !ps.started)
                return;
            if (ps.phase == PH_STRIP)
                bad_prefix();
            else if (ps.phase == PH_BODY && ps.held_ok)
                push_word(ST_DATA, ps.held, 1'b1);
            ps.held_ok    = 1'b0;
            ps.held       = 8'h00;
            ps.strip_wait = 1'b0;
            ps.phase      = PH_IDLE;
        endfunction

        function void flush_zeros();
            while (ps.zeros != 2'd0 && !ps.stuck)
            begin
                take_payload(8'h00);
                ps.zeros--;
            end
            ps.zeros = 2'd0;
        endfunction

        function void write_reg(logic [DFR_CFG_ADDR_W-1:0] addr, logic [DFR_CFG_DATA_W-1:0] d);
            case (cfg_addr_t'(addr))
                CFG_WRAP_ENABLE: regs.wrap_enable       = d[0];
                CFG_UNIT_TYPE:   regs.unit_type         = d[4:0];
                CFG_TEMPORAL_ID: regs.temporal_id_plus1 = d[2:0];
                default: ;
            endcase
        endfunction

        // Notes one accepted input word and appends the result words it causes.
        function void note_byte(logic [7:0] b, logic is_last);
            words_this_byte = 0;
            if (ps.stuck)
                return;
            if (b == 8'h00)
            begin
                // A fourth zero pushes the oldest held zero out as payload.
                if (ps.zeros == 2'd3)
                    take_payload(8'h00);
                else
                    ps.zeros++;
            end
            else if (b == START_CODE_TAIL && ps.zeros >= 2'd2)
            begin
                close_frame();
                ps.zeros = 2'd0;
                if (!ps.stuck)
                begin
                    ps.started = 1'b1;
                    ps.phase   = PH_IDLE;
                end
            end
            else
            begin
                flush_zeros();
                take_payload(b);
            end

            if (is_last && !ps.stuck)
            begin
                flush_zeros();
                close_frame();
                if (!ps.stuck)
                begin
                    push_word(status_t'(ps.started ? ST_END : ST_NO_START), 8'h00, 1'b0);
                    clear_stream();
                end
            end
        endfunction

        function void check_word(status_t s, logic [7:0] b, logic fl);
            dfr_result_t w;
            if (expected_words.size() == 0)
            begin
                $error("result word with nothing expected: status %0d, out_byte %02h, frame_last %0b",
                       s, b, fl);
                failures++;
                return;
            end
            w = expected_words.pop_front();
            if (s !== w.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", w.status, s);
                failures++;
            end
            if (b !== w.out_byte)
            begin
                $error("out_byte mismatch: expected %02h, actual %02h", w.out_byte, b);
                failures++;
            end
            if (fl !== w.frame_last)
            begin
                $error("frame_last mismatch: expected %0b, actual %0b", w.frame_last, fl);
                failures++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    dfr_in_if  in_ch();
    dfr_out_if out_ch();
    dfr_cfg_if cfg_ch();

    start_code_payload_deframer DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .ingress (in_ch),
        .egress  (out_ch),
        .cfg     (cfg_ch)
    );

    // sb checks the block; stim_track follows the stimulus as it is generated so that the
    // random part can steer clear of a bad prefix until the very end of the run.
    deframer_scoreboard sb;
    deframer_scoreboard stim_track;

    int sent_items = 0;
    int burst_left = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard limit on the run time.
    initial
    begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    // Every handshake is observed here, at the edge where it happens. A result word always
    // comes later than the byte that caused it, which passes the input register and the
    // result queue first, so the order of the two checks inside one edge does not matter.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_ch.valid && in_ch.ready)
                sb.note_byte(in_ch.data_byte, in_ch.is_last);
            if (out_ch.valid && out_ch.ready)
                sb.check_word(out_ch.status, out_ch.out_byte, out_ch.frame_last);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.addr, cfg_ch.wdata);
        end
    end

    // Receiver: stretches with a random share of ready cycles, from a full stall to always ready.
    initial
    begin
        int hold;
        int share;
        out_ch.ready = 1'b0;
        hold  = 0;
        share = 8;
        forever
        begin
            @(posedge clk);
            if (hold == 0)
            begin
                share = $urandom_range(0, 8);
                hold  = (share == 0) ? $urandom_range(1, 12) : $urandom_range(8, 64);
            end
            hold--;
            out_ch.ready <= ($urandom_range(0, 7) < share);
        end
    end

    // Drives one input word and waits until it is accepted. The sender works in bursts
    // of random length; between bursts valid drops for a random gap, or not at all.
    // valid stays high after acceptance so that the next word can follow at once.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.is_last   <= is_last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        burst_left--;
        sent_items++;
        stim_track.note_byte(b, is_last);
        stim_track.expected_words.delete();
    endtask

    // True when a word would trip the bad-prefix error, or would leave a 7C header opener
    // with zeros behind it, from where every continuation ends in that error.
    function automatic bit would_break(logic [7:0] b, logic is_last);
        parse_state_t saved;
        bit bad;
        saved = stim_track.ps;
        stim_track.note_byte(b, is_last);
        bad = stim_track.ps.stuck ||
              (stim_track.ps.phase == PH_STRIP && stim_track.ps.zeros != 2'd0);
        stim_track.ps = saved;
        stim_track.expected_words.delete();
        return bad;
    endfunction

    // Sends the wanted word if it is harmless, else the first harmless fallback. One of
    // 19, 01 or 00 without the end mark is always harmless in a reachable state.
    // Returns whether the word that went out carried the end mark.
    task automatic send_guarded(input logic [7:0] b, input logic is_last, output logic ended);
        logic [7:0] picks [4];
        logic [7:0] pick_byte;
        logic       pick_last;
        bit         found;
        picks[0]  = b;
        picks[1]  = PREFIX_BYTE;
        picks[2]  = START_CODE_TAIL;
        picks[3]  = 8'h00;
        found     = 1'b0;
        pick_byte = PREFIX_BYTE;
        pick_last = 1'b0;
        for (int pass = 0; pass < 2 && !found; pass++)
            for (int k = 0; k < 4 && !found; k++)
                if (!would_break(picks[k], (pass == 0) ? is_last : 1'b0))
                begin
                    pick_byte = picks[k];
                    pick_last = (pass == 0) ? is_last : 1'b0;
                    found     = 1'b1;
                end
        send_byte(pick_byte, pick_last);
        ended = pick_last;
    endtask

    // Payload content: heavy on zeros, 01 and the two prefix bytes so that zero runs,
    // accidental start codes and lookalike headers turn up inside bodies.
    function automatic logic [7:0] body_byte();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return 8'h00;
        else if (pick == 2)
            return START_CODE_TAIL;
        else if (pick == 3)
            return STRIP_FIRST;
        else if (pick == 4)
            return PREFIX_BYTE;
        else if (pick == 5)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // One random stream: optional noise, a few frames behind 3- or 4-byte start codes
    // with optional 7C 01 headers and empty payloads, then the end mark.
    task automatic random_stream();
        int   n_noise;
        int   n_frames;
        int   n_zeros;
        int   body_len;
        logic ended;
        n_noise = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
        for (int i = 0; i < n_noise; i++)
            send_guarded(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)),
                         1'b0, ended);
        // Now and then a stream holds no start code at all.
        n_frames = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
        for (int f = 0; f < n_frames; f++)
        begin
            n_zeros = ($urandom_range(0, 7) == 0) ? 4 : $urandom_range(2, 3);
            for (int z = 0; z < n_zeros; z++)
                send_guarded(8'h00, 1'b0, ended);
            send_guarded(START_CODE_TAIL, 1'b0, ended);
            if ($urandom_range(0, 7) != 0)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    send_guarded(STRIP_FIRST, 1'b0, ended);
                    send_guarded(STRIP_SECOND, 1'b0, ended);
                end
                send_guarded(PREFIX_BYTE, 1'b0, ended);
                body_len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 30)
                                                       : $urandom_range(0, 10);
                for (int i = 0; i < body_len; i++)
                    send_guarded(body_byte(), 1'b0, ended);
            end
        end
        ended = 1'b0;
        while (!ended)
            send_guarded(body_byte(), 1'b1, ended);
    endtask

    // Writes one register; valid stays high so that writes can follow back to back.
    task automatic put_reg(input logic [DFR_CFG_ADDR_W-1:0] addr,
                           input logic [DFR_CFG_DATA_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= addr;
        cfg_ch.wdata <= d;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // Loads a full register setting. The unused index gets junk first, and the upper bits
    // of every word are random so that masking is exercised.
    task automatic program_regs(input logic wrap, input logic [4:0] ut, input logic [2:0] tid);
        put_reg(CFG_UNUSED_ADDR, 8'($urandom_range(0, 255)));
        put_reg(CFG_WRAP_ENABLE, {7'($urandom_range(0, 127)), wrap});
        put_reg(CFG_UNIT_TYPE, {3'($urandom_range(0, 7)), ut});
        put_reg(CFG_TEMPORAL_ID, {5'($urandom_range(0, 31)), tid});
        cfg_ch.valid <= 1'b0;
    endtask

    // Holds the sender until every expected word has come and the block has settled.
    // The first edge lets the monitor note the byte accepted at the current edge.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int            phase_no;
        int            random_start;
        int            phase_start;
        prefix_fault_t fault;
        logic [7:0]    b;

        sb         = new();
        stim_track = new();

        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.is_last   = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.addr     = '0;
        cfg_ch.wdata    = '0;
        rst_n           = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with wrapping on so that the header words show up.
        program_regs(1'b1, 5'd19, 3'd5);
        // Noise before the first start code, including a 00 01 that is no start code.
        send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b0); send_byte(START_CODE_TAIL, 1'b0);
        // Four-byte start code, then a stripped 7C 01 header in front of the prefix.
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(START_CODE_TAIL, 1'b0);
        send_byte(STRIP_FIRST, 1'b0); send_byte(STRIP_SECOND, 1'b0);
        send_byte(PREFIX_BYTE, 1'b0);
        // A run of four zeros inside the body: all four become payload, the oldest at the fourth zero.
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
        // Three-byte start code closing the frame, then an empty payload.
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(START_CODE_TAIL, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(START_CODE_TAIL, 1'b0);
        // Short frame closed by the end of the stream.
        send_byte(PREFIX_BYTE, 1'b0); send_byte(8'h80, 1'b1);
        // A stream with no start code at all.
        send_byte(8'h55, 1'b0); send_byte(8'hAA, 1'b1);
        wait_idle();

        // Random part in phases; the sender pauses between phases until all words are in,
        // and the registers change while the block is idle.
        random_start = sent_items;
        phase_no     = 0;
        while (sent_items - random_start < RANDOM_ITEMS)
        begin
            case (phase_no)
                0: program_regs(1'b1, 5'd31, 3'd7);
                1: program_regs(1'b0, 5'd0, 3'd0);
                2: program_regs(1'b1, 5'd0, 3'd0);
                default: program_regs(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                                      3'($urandom_range(0, 7)));
            endcase
            phase_start = sent_items;
            while (sent_items - phase_start < ITEMS_PER_PHASE &&
                   sent_items - random_start < RANDOM_ITEMS)
                random_stream();
            wait_idle();
            phase_no++;
        end

        // A bad prefix can only be seen once, since reset never comes again, so it closes
        // the run: a wrong first byte, a payload of only 7C, or a second 7C 01 header.
        program_regs(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                     3'($urandom_range(0, 7)));
        fault = prefix_fault_t'($urandom_range(0, 2));
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(START_CODE_TAIL, 1'b0);
        case (fault)
            BAD_FIRST_BYTE:
            begin
                b = 8'($urandom_range(2, 255));
                if (b == PREFIX_BYTE || b == STRIP_FIRST)
                    b = 8'hA5;
                send_byte(b, 1'b0);
            end
            LONE_STRIP:
            begin
                send_byte(STRIP_FIRST, 1'b0);
                send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
                send_byte(START_CODE_TAIL, 1'b0);
            end
            default:
            begin
                send_byte(STRIP_FIRST, 1'b0); send_byte(STRIP_SECOND, 1'b0);
                send_byte(STRIP_FIRST, 1'b0);
            end
        endcase
        // Everything after the error is swallowed, a good frame and the end mark too.
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(START_CODE_TAIL, 1'b0);
        send_byte(PREFIX_BYTE, 1'b0); send_byte(8'h42, 1'b0); send_byte(8'h00, 1'b1);
        wait_idle();

        if (sb.failures == 0 && sb.expected_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
